@@ rtl/doubly_linked_list_cursor_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linked list cursor block
// Clocked property checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_CURSOR_ASSERT_SVH
`define DOUBLY_LINKED_LIST_CURSOR_ASSERT_SVH

// prop must hold at every clock edge outside reset
`define DLLC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define DLLC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/dllc_pkg.sv @@
// ----------------------------------------------------------------------------
// dllc_pkg
// Shared constants, types and op codes of the linked list cursor block.
// ----------------------------------------------------------------------------
package dllc_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 4;
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 5;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [OP_W-1:0]       op_t;

  localparam idx_t NONE = IDX_W'(CAPACITY);

  localparam op_t OP_PUSH_FRONT = 4'd0;
  localparam op_t OP_PUSH_BACK  = 4'd1;
  localparam op_t OP_INSERT     = 4'd2;
  localparam op_t OP_POP_FRONT  = 4'd3;
  localparam op_t OP_POP_BACK   = 4'd4;
  localparam op_t OP_POP_CURSOR = 4'd5;
  localparam op_t OP_FIRST      = 4'd6;
  localparam op_t OP_NEXT       = 4'd7;
  localparam op_t OP_LAST       = 4'd8;
  localparam op_t OP_PREV       = 4'd9;
  localparam op_t OP_CLEAR      = 4'd10;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    idx_t  wdata;
  } link_wr_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    val_t  wdata;
  } val_wr_t;

  function automatic logic is_node(idx_t i);
    return i < IDX_W'(CAPACITY);
  endfunction

  function automatic addr_t to_addr(idx_t i);
    return i[ADDR_W-1:0];
  endfunction

endpackage

@@ rtl/dllc_ram.sv @@
// ----------------------------------------------------------------------------
// dllc_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dllc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dllc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dllc_ctrl
// Op sequencer: head/tail/cursor/count registers, free map with lowest-index
// pick, and read-modify-write of the node link and value memories.
// ----------------------------------------------------------------------------
module dllc_ctrl
  import dllc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        op_i,
  input  logic [DATA_W-1:0]      value_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      value_out_o,
  output logic                   found_o,
  output logic                   rejected_o,
  output logic [COUNT_OUT_W-1:0] node_count_o,
  output addr_t                  rd_addr_o,
  output link_wr_t               next_wr_o,
  output link_wr_t               prev_wr_o,
  output val_wr_t                val_wr_o,
  input  idx_t                   next_rd_i,
  input  idx_t                   prev_rd_i,
  input  val_t                   val_rd_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WR2  = 2'd2;
  localparam logic [1:0] S_RD2  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CAPACITY-1:0] used_q, used_d;
  idx_t                head_q, head_d;
  idx_t                tail_q, tail_d;
  idx_t                cursor_q, cursor_d;
  cnt_t                count_q, count_d;
  logic                done_q, done_d;

  op_t                 op_q, op_d;
  val_t                value_q, value_d;
  idx_t                t_q, t_d;
  idx_t                n_q, n_d;
  idx_t                anchor_q, anchor_d;
  idx_t                after_q, after_d;
  logic [DATA_W-1:0]   res_value_q, res_value_d;
  logic                found_q, found_d;
  logic                rej_q, rej_d;
  logic [COUNT_OUT_W-1:0] cnt_out_q, cnt_out_d;

  idx_t t_sel;
  idx_t pick;
  logic full;
  idx_t anchor;
  idx_t after;
  idx_t tgt;

  // read target chosen at accept
  always_comb begin
    case (op_i) inside
      OP_PUSH_BACK, OP_POP_BACK, OP_LAST:            t_sel = tail_q;
      OP_POP_FRONT, OP_FIRST:                        t_sel = head_q;
      OP_INSERT, OP_POP_CURSOR, OP_NEXT, OP_PREV:    t_sel = cursor_q;
      default:                                       t_sel = NONE;
    endcase
  end

  // lowest free node
  always_comb begin
    pick = NONE;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        pick = IDX_W'(i);
      end
    end
  end

  assign full   = &used_q;
  assign anchor = (op_q == OP_PUSH_FRONT) ? NONE : t_q;
  assign after  = is_node(anchor) ? next_rd_i : head_q;
  assign tgt    = (op_q == OP_NEXT) ? next_rd_i : prev_rd_i;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    logic finish;
    logic fnd;
    logic rej;
    val_t rval;

    finish      = 1'b0;
    fnd         = 1'b0;
    rej         = 1'b0;
    rval        = '0;

    state_d     = state_q;
    used_d      = used_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    op_d        = op_q;
    value_d     = value_q;
    t_d         = t_q;
    n_d         = n_q;
    anchor_d    = anchor_q;
    after_d     = after_q;
    res_value_d = res_value_q;
    found_d     = found_q;
    rej_d       = rej_q;
    cnt_out_d   = cnt_out_q;

    rd_addr_o   = to_addr(t_q);
    next_wr_o   = '{we: 1'b0, waddr: to_addr(n_q), wdata: NONE};
    prev_wr_o   = '{we: 1'b0, waddr: to_addr(n_q), wdata: NONE};
    val_wr_o    = '{we: 1'b0, waddr: to_addr(n_q), wdata: value_q};

    unique case (state_q)
      S_IDLE: begin
        rd_addr_o = to_addr(t_sel);
        if (start) begin
          op_d    = op_i;
          value_d = val_t'(value_i);
          t_d     = t_sel;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_q) inside
          OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
            if (full) begin
              finish = 1'b1;
              rej    = 1'b1;
            end else begin
              n_d       = pick;
              anchor_d  = anchor;
              after_d   = after;
              val_wr_o  = '{we: 1'b1, waddr: to_addr(pick), wdata: value_q};
              next_wr_o = '{we: 1'b1, waddr: to_addr(pick), wdata: after};
              prev_wr_o = '{we: 1'b1, waddr: to_addr(pick), wdata: anchor};
              state_d   = S_WR2;
            end
          end
          OP_POP_FRONT, OP_POP_BACK, OP_POP_CURSOR: begin
            finish   = 1'b1;
            cursor_d = t_q;
            if (is_node(t_q)) begin
              fnd  = 1'b1;
              rval = val_rd_i;
              if (is_node(prev_rd_i)) begin
                next_wr_o = '{we: 1'b1, waddr: to_addr(prev_rd_i), wdata: next_rd_i};
              end else begin
                head_d = next_rd_i;
              end
              if (is_node(next_rd_i)) begin
                prev_wr_o = '{we: 1'b1, waddr: to_addr(next_rd_i), wdata: prev_rd_i};
              end else begin
                tail_d = prev_rd_i;
              end
              cursor_d               = is_node(next_rd_i) ? next_rd_i : NONE;
              used_d[to_addr(t_q)]   = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - cnt_t'(1);
              end
            end
          end
          OP_FIRST, OP_LAST: begin
            finish = 1'b1;
            if (is_node(t_q)) begin
              fnd      = 1'b1;
              rval     = val_rd_i;
              cursor_d = t_q;
            end
          end
          OP_NEXT, OP_PREV: begin
            if (is_node(t_q) && is_node(tgt)) begin
              t_d       = tgt;
              rd_addr_o = to_addr(tgt);
              state_d   = S_RD2;
            end else begin
              finish = 1'b1;
            end
          end
          OP_CLEAR: begin
            finish   = 1'b1;
            used_d   = '0;
            head_d   = NONE;
            tail_d   = NONE;
            cursor_d = NONE;
            count_d  = '0;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      S_WR2: begin
        finish = 1'b1;
        if (is_node(anchor_q)) begin
          next_wr_o = '{we: 1'b1, waddr: to_addr(anchor_q), wdata: n_q};
        end else begin
          head_d = n_q;
        end
        if (is_node(after_q)) begin
          prev_wr_o = '{we: 1'b1, waddr: to_addr(after_q), wdata: n_q};
        end else begin
          tail_d = n_q;
        end
        used_d[to_addr(n_q)] = 1'b1;
        count_d              = count_q + cnt_t'(1);
        if (op_q == OP_PUSH_BACK) begin
          cursor_d = anchor_q;
        end
      end

      S_RD2: begin
        finish   = 1'b1;
        fnd      = 1'b1;
        rval     = val_rd_i;
        cursor_d = t_q;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    done_d = finish;
    if (finish) begin
      state_d     = S_IDLE;
      res_value_d = fnd ? DATA_W'(rval) : '0;
      found_d     = fnd;
      rej_d       = rej;
      cnt_out_d   = COUNT_OUT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      head_q   <= NONE;
      tail_q   <= NONE;
      cursor_q <= NONE;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    value_q     <= value_d;
    t_q         <= t_d;
    n_q         <= n_d;
    anchor_q    <= anchor_d;
    after_q     <= after_d;
    res_value_q <= res_value_d;
    found_q     <= found_d;
    rej_q       <= rej_d;
    cnt_out_q   <= cnt_out_d;
  end

  assign done_o       = done_q;
  assign value_out_o  = res_value_q;
  assign found_o      = found_q;
  assign rejected_o   = rej_q;
  assign node_count_o = cnt_out_q;

endmodule

@@ rtl/doubly_linked_list_cursor.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor
// Doubly linked list with a cursor over a fixed node pool; links and data
// words live in synchronous RAMs, list registers in the sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | start, busy        | op_i, value_i
//  result   | done_o (1 cycle)   | value_out_o, found_o, rejected_o,
//           |                    | node_count_o
//
//  An item is taken when start is high and busy is low, which issues its RAM read;
//  its result is registered from S_EXEC (pops, first, last, clear, unused codes,
//  full-pool pushes, next/prev with no neighbor) or from S_WR2 (other pushes:
//  second link write) or S_RD2 (next/prev that move: second RAM read).
//  busy falls as done_o rises, so the next item can go with the result.
//  Reset clears the list registers and free map; results cannot be stalled.
// ----------------------------------------------------------------------------
module doubly_linked_list_cursor
  import dllc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        op_i,
  input  logic [DATA_W-1:0]      value_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      value_out_o,
  output logic                   found_o,
  output logic                   rejected_o,
  output logic [COUNT_OUT_W-1:0] node_count_o
);

  addr_t    rd_addr;
  link_wr_t next_wr;
  link_wr_t prev_wr;
  val_wr_t  val_wr;
  idx_t     next_rd;
  idx_t     prev_rd;
  val_t     val_rd;

  dllc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .value_out_o  (value_out_o),
    .found_o      (found_o),
    .rejected_o   (rejected_o),
    .node_count_o (node_count_o),
    .rd_addr_o    (rd_addr),
    .next_wr_o    (next_wr),
    .prev_wr_o    (prev_wr),
    .val_wr_o     (val_wr),
    .next_rd_i    (next_rd),
    .prev_rd_i    (prev_rd),
    .val_rd_i     (val_rd)
  );

  dllc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_wr.we),
    .waddr_i (next_wr.waddr),
    .wdata_i (next_wr.wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rd)
  );

  dllc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_wr.we),
    .waddr_i (prev_wr.waddr),
    .wdata_i (prev_wr.wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  dllc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_wr.we),
    .waddr_i (val_wr.waddr),
    .wdata_i (val_wr.wdata),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

endmodule

@@ rtl/dllc_checker.sv @@
// ----------------------------------------------------------------------------
// dllc_checker
// Port-level checks of the linked list cursor block, bound to the top level.
// ----------------------------------------------------------------------------
`include "doubly_linked_list_cursor_assert.svh"

module dllc_checker
  import dllc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input logic                   found_o,
  input logic                   rejected_o,
  input logic [COUNT_OUT_W-1:0] node_count_o
);

  `DLLC_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "accepted item not busy")
  `DLLC_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "result while still busy")
  `DLLC_ASSERT(a_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy), "result without an item")
  `DLLC_ASSERT_NEVER(a_found_rej, clk_i, rst_ni, done_o && found_o && rejected_o, "found and rejected")
  `DLLC_ASSERT(a_count_max, clk_i, rst_ni, done_o |-> node_count_o <= COUNT_OUT_W'(CAPACITY), "count over capacity")

endmodule

bind doubly_linked_list_cursor dllc_checker u_dllc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .found_o      (found_o),
  .rejected_o   (rejected_o),
  .node_count_o (node_count_o)
);
